// ----- rtl/core/bpd_pkg.sv -----
// Shared types, codes and helpers for the Bezier point and derivatives unit.
package bpd_pkg;

	localparam int MAX_POINTS_DEF  = 8;
	localparam int T_FRAC_BITS_DEF = 16;
	localparam int COORD_W         = 32;
	localparam int T_PORT_W        = 17;
	localparam int IDX_W           = 3;
	localparam int PADDR_W         = 3;
	localparam int PDATA_W         = 32;
	localparam int PC_W            = 4;

	// request kinds
	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_EVAL  = 1'b1;

	// register byte addresses
	localparam logic [PADDR_W-1:0] REG_POINT_COUNT = 3'd0;

	// three coordinates x, y, z as index 0, 1, 2
	typedef logic [2:0][COORD_W-1:0] vec3_t;

	// per-cycle commands to the cell chain
	typedef struct packed {
		logic wr;
		logic load;
		logic mul;
		logic add;
	} cell_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_CHECK,
		ST_MUL,
		ST_ADD,
		ST_FIN1,
		ST_FIN2
	} bpd_state_t;

	// clamp a wide signed value to the 32-bit coordinate range
	function automatic logic [COORD_W-1:0] sat32(input logic signed [79:0] v);
		logic signed [79:0] hi;
		logic signed [79:0] lo;
		hi = 80'sd2147483647;
		lo = -80'sd2147483648;
		if (v > hi) begin
			sat32 = 32'h7fff_ffff;
		end else if (v < lo) begin
			sat32 = 32'h8000_0000;
		end else begin
			sat32 = v[COORD_W-1:0];
		end
	endfunction

endpackage

// ----- rtl/core/bpd_if.sv -----
// Request and result channel interfaces of the Bezier unit.
interface bpd_req_if;
	logic                          valid;
	logic                          ready;
	logic                          kind;
	logic [bpd_pkg::IDX_W-1:0]     point_index;
	logic signed [31:0]            coord_x;
	logic signed [31:0]            coord_y;
	logic signed [31:0]            coord_z;
	logic [bpd_pkg::T_PORT_W-1:0]  t_param;

	modport source (output valid, kind, point_index, coord_x, coord_y, coord_z, t_param,
		input ready);
	modport sink (input valid, kind, point_index, coord_x, coord_y, coord_z, t_param,
		output ready);
endinterface

interface bpd_res_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] point_x;
	logic signed [31:0] point_y;
	logic signed [31:0] point_z;
	logic signed [31:0] slope_x;
	logic signed [31:0] slope_y;
	logic signed [31:0] slope_z;
	logic signed [31:0] bend_x;
	logic signed [31:0] bend_y;
	logic signed [31:0] bend_z;

	modport source (output valid, point_x, point_y, point_z, slope_x, slope_y, slope_z,
		bend_x, bend_y, bend_z, input ready);
	modport sink (input valid, point_x, point_y, point_z, slope_x, slope_y, slope_z,
		bend_x, bend_y, bend_z, output ready);
endinterface

// ----- rtl/core/bpd_cell.sv -----
// One cell of the de Casteljau chain: a stored control point and a working point.
module bpd_cell #(
	parameter int T_FRAC_BITS = bpd_pkg::T_FRAC_BITS_DEF,
	parameter int CELL_INDEX  = 0
) (
	input  logic                        clk,
	input  bpd_pkg::cell_ctl_t          ctl,
	input  logic [bpd_pkg::IDX_W-1:0]   wr_idx,
	input  bpd_pkg::vec3_t              wr_pt,
	input  logic [T_FRAC_BITS:0]        t_val,
	input  bpd_pkg::vec3_t              nb_w,
	output bpd_pkg::vec3_t              w
);
	import bpd_pkg::*;

	localparam int PW = COORD_W + T_FRAC_BITS + 3;

	vec3_t                store_q;
	vec3_t                work_q;
	logic signed [PW-1:0] prod_q [3];
	logic signed [PW-1:0] rnd    [3];
	logic signed [T_FRAC_BITS+1:0] t_s;

	assign t_s = {1'b0, t_val};
	assign w   = work_q;

	// control point store
	always_ff @(posedge clk) begin
		if (ctl.wr && (32'(wr_idx) == CELL_INDEX)) begin
			store_q <= wr_pt;
		end
	end

	// rounded step toward the neighbor: floor((d*t + half) / 2^F)
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			rnd[k] = (prod_q[k] + (PW'(1) <<< (T_FRAC_BITS - 1))) >>> T_FRAC_BITS;
		end
	end

	// multiply stage, then add stage
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			if (ctl.mul) begin
				prod_q[k] <= PW'($signed({nb_w[k][COORD_W-1], nb_w[k]})
					- $signed({work_q[k][COORD_W-1], work_q[k]})) * PW'(t_s);
			end
		end
		if (ctl.load) begin
			work_q <= store_q;
		end else if (ctl.add) begin
			for (int k = 0; k < 3; k++) begin
				work_q[k] <= work_q[k] + rnd[k][COORD_W-1:0];
			end
		end
	end

endmodule

// ----- rtl/core/bezier_point_and_derivatives_unit.sv -----
// Bezier point and derivatives unit: evaluates a curve of up to MAX_POINTS
// control points with de Casteljau in Q16.16 on a chain of cells, one cell per
// control point, each with one multiplier per coordinate. A write request
// stores one point, so writes can follow back to back.
// An evaluate request keeps the request side busy through the load, then per
// pyramid level a check, multiply and add, then a last check and the finishing
// states FIN1 and FIN2 for the derivative scaling; with no points it goes
// straight to FIN1, and FIN2 also waits for the result register to be free.
// Results: curve point, degree*(Q1-Q0) and degree*(degree-1)*second difference,
// the last two saturated; fields that do not apply to the point count are zero.
module bezier_point_and_derivatives_unit #(
	parameter int MAX_POINTS  = bpd_pkg::MAX_POINTS_DEF,
	parameter int T_FRAC_BITS = bpd_pkg::T_FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	bpd_req_if.sink                       src,
	bpd_res_if.source                     dst,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bpd_pkg::PADDR_W-1:0]   paddr,
	input  logic [bpd_pkg::PDATA_W-1:0]   pwdata,
	output logic [bpd_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);
	import bpd_pkg::*;

	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int NW = (MAX_POINTS < 3) ? 3 : MAX_POINTS;
	localparam logic [T_FRAC_BITS:0] T_ONE = (T_FRAC_BITS+1)'(1) << T_FRAC_BITS;

	bpd_state_t state_q, state_d;
	logic [PC_W-1:0]        point_count_q;
	logic [CW-1:0]          n_q, c_q, n_eff;
	logic [T_FRAC_BITS:0]   t_q, t_raw;
	logic [2*CW-1:0]        coef_q;
	cell_ctl_t              ctl;
	vec3_t                  w_all [NW];
	vec3_t                  wr_pt;
	vec3_t                  bd_q [3];
	vec3_t                  sd_q [2];
	logic signed [32:0]     d1_q [3];
	logic signed [33:0]     e_q  [3];
	logic signed [33+CW:0]  slope_full [3];
	logic signed [34+2*CW:0] bend_full [3];
	logic [CW-1:0]          deg;
	logic                   out_valid_q;
	vec3_t                  pt_q, sl_q, bn_q;
	logic                   req_acc, cfg_wr, out_free;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr == REG_POINT_COUNT) ? PDATA_W'(point_count_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= '0;
		end else if (cfg_wr && (paddr == REG_POINT_COUNT)) begin
			point_count_q <= pwdata[PC_W-1:0];
		end
	end

	// request side
	assign src.ready = (state_q == ST_IDLE);
	assign req_acc   = src.valid && src.ready;
	assign n_eff     = (32'(point_count_q) > MAX_POINTS) ? CW'(MAX_POINTS) : CW'(point_count_q);
	assign t_raw     = (T_FRAC_BITS+1)'(src.t_param);
	assign wr_pt     = {src.coord_z, src.coord_y, src.coord_x};
	assign out_free  = !out_valid_q || dst.ready;
	assign deg       = n_q - CW'(1);

	// cell chain
	genvar gi;
	generate
		for (gi = 0; gi < NW; gi++) begin : g_cell
			if (gi < MAX_POINTS) begin : g_live
				bpd_cell #(.T_FRAC_BITS(T_FRAC_BITS), .CELL_INDEX(gi)) u_cell (
					.clk    (clk),
					.ctl    (ctl),
					.wr_idx (src.point_index),
					.wr_pt  (wr_pt),
					.t_val  (t_q),
					.nb_w   (w_all[(gi + 1 < MAX_POINTS) ? gi + 1 : gi]),
					.w      (w_all[gi])
				);
			end else begin : g_pad
				assign w_all[gi] = '0;
			end
		end
	endgenerate

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		ctl      = '0;
		case (state_q)
			ST_IDLE: begin
				if (req_acc) begin
					if (src.kind == KIND_WRITE) begin
						ctl.wr = 1'b1;
					end else if (n_eff == '0) begin
						state_d = ST_FIN1;
					end else begin
						state_d = ST_LOAD;
					end
				end
			end
			ST_LOAD: begin
				ctl.load = 1'b1;
				state_d  = ST_CHECK;
			end
			ST_CHECK: begin
				state_d = (c_q <= CW'(1)) ? ST_FIN1 : ST_MUL;
			end
			ST_MUL: begin
				ctl.mul = 1'b1;
				state_d = ST_ADD;
			end
			ST_ADD: begin
				ctl.add = 1'b1;
				state_d = ST_CHECK;
			end
			ST_FIN1: begin
				state_d = ST_FIN2;
			end
			ST_FIN2: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// level counter, parameter and pyramid taps
	always_ff @(posedge clk) begin
		if (req_acc) begin
			n_q <= n_eff;
			c_q <= n_eff;
			t_q <= (t_raw > T_ONE) ? T_ONE : t_raw;
		end
		if (state_q == ST_ADD) begin
			c_q <= c_q - CW'(1);
		end
		if (state_q == ST_CHECK) begin
			if (32'(c_q) == 3) begin
				bd_q[0] <= w_all[0];
				bd_q[1] <= w_all[1];
				bd_q[2] <= w_all[2];
			end
			if (32'(c_q) == 2) begin
				sd_q[0] <= w_all[0];
				sd_q[1] <= w_all[1];
			end
		end
		if (state_q == ST_FIN1) begin
			coef_q <= (2*CW)'(deg) * (2*CW)'(deg - CW'(1));
			for (int k = 0; k < 3; k++) begin
				d1_q[k] <= $signed({sd_q[1][k][31], sd_q[1][k]})
					- $signed({sd_q[0][k][31], sd_q[0][k]});
				e_q[k] <= ($signed({{2{bd_q[2][k][31]}}, bd_q[2][k]})
					- $signed({{2{bd_q[1][k][31]}}, bd_q[1][k]}))
					- ($signed({{2{bd_q[1][k][31]}}, bd_q[1][k]})
					- $signed({{2{bd_q[0][k][31]}}, bd_q[0][k]}));
			end
		end
	end

	// derivative scaling
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			slope_full[k] = (34+CW)'(d1_q[k]) * (34+CW)'($signed({1'b0, deg}));
			bend_full[k]  = (35+2*CW)'(e_q[k]) * (35+2*CW)'($signed({1'b0, coef_q}));
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FIN2 && out_free) begin
			out_valid_q <= 1'b1;
		end else if (dst.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN2 && out_free) begin
			for (int k = 0; k < 3; k++) begin
				pt_q[k] <= (n_q >= CW'(1)) ? w_all[0][k] : '0;
				sl_q[k] <= (32'(n_q) >= 2) ? sat32(80'(slope_full[k])) : '0;
				bn_q[k] <= (32'(n_q) >= 3) ? sat32(80'(bend_full[k])) : '0;
			end
		end
	end

	assign dst.valid   = out_valid_q;
	assign dst.point_x = pt_q[0];
	assign dst.point_y = pt_q[1];
	assign dst.point_z = pt_q[2];
	assign dst.slope_x = sl_q[0];
	assign dst.slope_y = sl_q[1];
	assign dst.slope_z = sl_q[2];
	assign dst.bend_x  = bn_q[0];
	assign dst.bend_y  = bn_q[1];
	assign dst.bend_z  = bn_q[2];

endmodule
